// ===== design/slc_ofs_pkg.sv =====
package slc_ofs_pkg;

  // Table geometry
  localparam int unsigned MaxLevels  = 16;
  localparam int unsigned MaxSlices  = 64;
  localparam int unsigned TableDepth = MaxLevels * MaxSlices;
  localparam int unsigned AddrW      = $clog2(TableDepth);
  localparam int unsigned EntryW     = 32;
  localparam int unsigned CfgW       = 19;

  // Item operations
  localparam logic OpLoad  = 1'b0;
  localparam logic OpQuery = 1'b1;

  // Tiling modes; any other code is treated as linear
  localparam logic [1:0] TileLinear = 2'd0;
  localparam logic [1:0] TileX      = 2'd1;
  localparam logic [1:0] TileY      = 2'd2;

  // Configuration register indexes
  localparam logic [2:0] RegTiling   = 3'd0;
  localparam logic [2:0] RegPitch    = 3'd1;
  localparam logic [2:0] RegBlkBytes = 3'd2;
  localparam logic [2:0] RegBlkWLog2 = 3'd3;
  localparam logic [2:0] RegBlkHLog2 = 3'd4;

  // 512 / bytes_per_block; the Y tile width (128) uses this value shifted right by two
  localparam logic [9:0] XDIV_TBL [32] = '{
    10'd0,   10'd512, 10'd256, 10'd170, 10'd128, 10'd102, 10'd85,  10'd73,
    10'd64,  10'd56,  10'd51,  10'd46,  10'd42,  10'd39,  10'd36,  10'd34,
    10'd32,  10'd30,  10'd28,  10'd26,  10'd25,  10'd24,  10'd23,  10'd22,
    10'd21,  10'd20,  10'd19,  10'd18,  10'd18,  10'd17,  10'd17,  10'd16
  };

  typedef struct packed {
    logic [1:0]  tiling;
    logic [18:0] pitch;
    logic [4:0]  blk_bytes;
    logic [1:0]  blk_w_log2;
    logic [1:0]  blk_h_log2;
  } cfg_t;

  typedef struct packed {
    logic [31:0] byte_offset;
    logic [8:0]  intra_x;
    logic [7:0]  intra_y;
  } result_t;

endpackage

// ===== design/slc_ofs_table.sv =====
module slc_ofs_table (
  input  logic                               clk_i,
  input  logic                               we_i,
  input  logic                               re_i,
  input  logic [slc_ofs_pkg::AddrW-1:0]      addr_i,
  input  logic [slc_ofs_pkg::EntryW-1:0]     wdata_i,
  output logic [slc_ofs_pkg::EntryW-1:0]     rdata_o
);

  logic [slc_ofs_pkg::EntryW-1:0] mem_q [slc_ofs_pkg::TableDepth];
  logic [slc_ofs_pkg::EntryW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/slc_ofs_core.sv =====
module slc_ofs_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            aligned_i,
  input  slc_ofs_pkg::cfg_t               cfg_i,
  input  logic [slc_ofs_pkg::EntryW-1:0]  entry_i,
  output logic                            idle_o,
  output logic                            res_valid_o,
  input  logic                            res_ready_i,
  output slc_ofs_pkg::result_t            res_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMulX = 3'd1;
  localparam logic [2:0] StMulY = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StDone = 3'd4;

  logic [2:0]  state_q, state_d;
  logic        aligned_q;
  logic [20:0] xb_q;
  logic [31:0] py_q;
  logic [9:0]  rem_q, rem_d;
  logic [3:0]  cnt_q;

  logic [15:0] x_pix, y_pix, y_row;
  logic        is_x, is_y, tiled, div_en;
  logic [18:0] mul_a;
  logic [15:0] mul_b;
  logic [34:0] mul_p;
  logic [9:0]  dvs, rem_sh;
  logic [31:0] base, off;
  logic [11:0] low;
  logic [8:0]  xo;
  logic [7:0]  yo;

  // The entry register stays put while an item is in flight
  assign x_pix = entry_i[15:0] >> cfg_i.blk_w_log2;
  assign y_pix = entry_i[31:16] >> cfg_i.blk_h_log2;

  assign is_x   = (cfg_i.tiling == slc_ofs_pkg::TileX);
  assign is_y   = (cfg_i.tiling == slc_ofs_pkg::TileY);
  assign tiled  = is_x || is_y;
  assign div_en = tiled && aligned_q && (cfg_i.blk_bytes != 5'd0);

  always_comb begin
    if (is_x) begin
      y_row = y_pix >> 3;
    end else if (is_y) begin
      y_row = y_pix >> 5;
    end else begin
      y_row = y_pix;
    end
  end

  // Shared multiplier: x * bytes_per_block first, then tile row * pitch
  always_comb begin
    if (state_q == StMulX) begin
      mul_a = {14'd0, cfg_i.blk_bytes};
      mul_b = x_pix;
    end else begin
      mul_a = cfg_i.pitch;
      mul_b = y_row;
    end
  end
  assign mul_p = {16'd0, mul_a} * {19'd0, mul_b};

  // Restoring remainder step: x mod (tile width / bytes_per_block), one bit a cycle
  assign dvs    = is_y ? (slc_ofs_pkg::XDIV_TBL[cfg_i.blk_bytes] >> 2)
                       : slc_ofs_pkg::XDIV_TBL[cfg_i.blk_bytes];
  assign rem_sh = {rem_q[8:0], x_pix[cnt_q]};
  assign rem_d  = (rem_sh >= dvs) ? (rem_sh - dvs) : rem_sh;

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (start_i) state_d = StMulX;
      end
      StMulX: state_d = StMulY;
      StMulY: state_d = div_en ? StDiv : StDone;
      StDiv: begin
        if (cnt_q == 4'd0) state_d = StDone;
      end
      StDone: begin
        if (res_ready_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      aligned_q <= aligned_i;
    end
    if (state_q == StMulX) begin
      xb_q <= mul_p[20:0];
    end
    if (state_q == StMulY) begin
      py_q  <= mul_p[31:0];
      rem_q <= '0;
      cnt_q <= 4'd15;
    end
    if (state_q == StDiv) begin
      rem_q <= rem_d;
      cnt_q <= cnt_q - 4'd1;
    end
  end

  // Tile start plus the swizzled position inside the tile
  always_comb begin
    if (is_x) begin
      base = {py_q[28:0], 3'd0} + {8'd0, xb_q[20:9], 12'd0};
      low  = {y_pix[2:0], xb_q[8:0]};
      yo   = {5'd0, y_pix[2:0]} << cfg_i.blk_h_log2;
    end else if (is_y) begin
      base = {py_q[26:0], 5'd0} + {6'd0, xb_q[20:7], 12'd0};
      low  = {xb_q[6:4], y_pix[4:0], xb_q[3:0]};
      yo   = {3'd0, y_pix[4:0]} << cfg_i.blk_h_log2;
    end else begin
      base = py_q + {11'd0, xb_q};
      low  = '0;
      yo   = '0;
    end
    xo = rem_q[8:0] << cfg_i.blk_w_log2;
  end

  always_comb begin
    if (tiled && aligned_q) begin
      off = base;
      res_o.intra_x = xo;
      res_o.intra_y = yo;
    end else begin
      off = base + {20'd0, low};
      res_o.intra_x = '0;
      res_o.intra_y = '0;
    end
    res_o.byte_offset = off;
  end

  assign idle_o      = (state_q == StIdle);
  assign res_valid_o = (state_q == StDone);

endmodule

// ===== design/tiled_surface_slice_offset.sv =====
// Slice offset unit for linear, X-tiled (512x8) and Y-tiled (128x32) surfaces. A load item
// writes one slice origin into a 1024-entry table; the block is ready again in the next
// cycle. A query item reads its entry, runs through one shared multiplier twice (x times
// block bytes, tile row times pitch) and holds its result until the output register takes
// it; no next item is accepted before then. A tile-aligned query on a tiled surface with a
// nonzero block size also needs the pixel remainder inside the tile, which a bit-serial
// remainder unit works out after the multiplies. Results leave through an output register,
// so a new item is taken while a finished result still waits. Table entries hold no value
// until loaded; querying an entry that was never loaded gives no defined answer. The user
// must write configuration only while the block is idle; the block does not enforce it.
module tiled_surface_slice_offset (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [18:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        operation_i,
  input  logic [3:0]  mip_level_i,
  input  logic [5:0]  slice_index_i,
  input  logic [15:0] origin_x_i,
  input  logic [15:0] origin_y_i,
  input  logic        tile_aligned_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] byte_offset_o,
  output logic [8:0]  intra_x_o,
  output logic [7:0]  intra_y_o
);

  slc_ofs_pkg::cfg_t    cfg_q;
  slc_ofs_pkg::result_t res, out_q;
  logic                 out_valid_q;
  logic                 accept, core_idle, res_valid, res_ready;
  logic                 tbl_we, tbl_re;
  logic [slc_ofs_pkg::EntryW-1:0] entry;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tiling     <= slc_ofs_pkg::TileLinear;
      cfg_q.pitch      <= '0;
      cfg_q.blk_bytes  <= 5'd1;
      cfg_q.blk_w_log2 <= '0;
      cfg_q.blk_h_log2 <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        slc_ofs_pkg::RegTiling:   cfg_q.tiling     <= cfg_wdata_i[1:0];
        slc_ofs_pkg::RegPitch:    cfg_q.pitch      <= cfg_wdata_i;
        slc_ofs_pkg::RegBlkBytes: cfg_q.blk_bytes  <= cfg_wdata_i[4:0];
        slc_ofs_pkg::RegBlkWLog2: cfg_q.blk_w_log2 <= cfg_wdata_i[1:0];
        slc_ofs_pkg::RegBlkHLog2: cfg_q.blk_h_log2 <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = core_idle;
  assign accept     = in_valid_i && core_idle;
  assign tbl_we     = accept && (operation_i == slc_ofs_pkg::OpLoad);
  assign tbl_re     = accept && (operation_i == slc_ofs_pkg::OpQuery);

  slc_ofs_table u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .re_i    (tbl_re),
    .addr_i  ({mip_level_i, slice_index_i}),
    .wdata_i ({origin_y_i, origin_x_i}),
    .rdata_o (entry)
  );

  slc_ofs_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (tbl_re),
    .aligned_i   (tile_aligned_i),
    .cfg_i       (cfg_q),
    .entry_i     (entry),
    .idle_o      (core_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: take a new result when empty or being drained
  assign res_ready = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_offset_o = out_q.byte_offset;
  assign intra_x_o     = out_q.intra_x;
  assign intra_y_o     = out_q.intra_y;

endmodule

// ===== design/slc_ofs_chk.sv =====
module slc_ofs_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        operation_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] byte_offset_i,
  input logic [8:0]  intra_x_i,
  input logic [7:0]  intra_y_i
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_offset_i)
      && $stable(intra_x_i) && $stable(intra_y_i))
    else $error("result changed while stalled");

  // A query occupies the block
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && operation_i |=> !in_ready_i)
    else $error("ready stayed high after a query item");

  // After a load the block is ready again in the next cycle
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !operation_i |=> in_ready_i)
    else $error("ready dropped after a load item");

  // A new result only comes out of a busy block
  a_out_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared without a query in flight");

endmodule

bind tiled_surface_slice_offset slc_ofs_chk u_slc_ofs_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_ready_i    (in_ready_o),
  .operation_i   (operation_i),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .byte_offset_i (byte_offset_o),
  .intra_x_i     (intra_x_o),
  .intra_y_i     (intra_y_o)
);
